### src/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 keystream generator package
// Shared widths, constants, command codes and the controller state type.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned IdxW = 8;
  localparam int unsigned CntW = 9;
  localparam int unsigned TableDepth = 256;

  localparam logic [CntW-1:0] KeyCntFull = 9'd256;
  localparam logic [IdxW-1:0] IdxLast = 8'hFF;

  localparam logic ModeKeyLoad = 1'b0;
  localparam logic ModeRequest = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StInit,
    StKsRdK,
    StKsRdL,
    StKsWrK,
    StKsWrL,
    StRqRdI,
    StRqRdJ,
    StRqWrI,
    StRqWrJ
  } state_e;

endpackage

### src/rc4_ram.sv
// ----------------------------------------------------------------------------
// RC4 simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/rc4_keystream_generator_core.sv
// ----------------------------------------------------------------------------
// RC4 keystream generator core
// Loads a key, runs the key schedule and produces keystream bytes on request.
// ----------------------------------------------------------------------------
// Usage: a command is transferred at a rising edge with start high and busy
// low. A key-load command (mode 0) writes key_byte_i into the key store in
// that cycle and produces no result; busy stays low unless key_last_i is set.
// With key_last_i set the core runs the key schedule: it fills the permutation
// with the identity in StInit, then runs each of the 256 mixing steps through
// StKsRdK, StKsRdL, StKsWrK and StKsWrL; busy is high throughout.
// A request command (mode 1) produces exactly one result, shown for one cycle
// with valid_o high. Once keyed, busy is high through the states StRqRdI
// (read S[i]), StRqRdJ (read S[j]), StRqWrI (swap and read the output entry)
// and StRqWrJ (final write), and the result appears in the cycle after; a new
// request is taken only once busy is low. The sequence is set by the single read
// and single write port of the permutation memory. Before any key schedule a
// request returns 0 with keyed_o low in the next cycle and busy stays low.
// Reset clears the indices, the key count and the keyed flag; the memories
// are left as they are; the permutation is fully written by the first key schedule.
// The receiver cannot stall: each result must be taken in its cycle.
// ----------------------------------------------------------------------------
module rc4_keystream_generator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       mode_i,
  input  logic [7:0] key_byte_i,
  input  logic       key_last_i,
  output logic       valid_o,
  output logic [7:0] keystream_byte_o,
  output logic       keyed_o
);

  rc4_pkg::state_e state_q, state_d;

  logic                     accept;
  logic [rc4_pkg::CntW-1:0] key_cnt_q, key_cnt_d, key_cnt_inc;
  logic [rc4_pkg::CntW-1:0] key_len_q, key_len_d;
  logic [rc4_pkg::IdxW-1:0] i_q, i_d, j_q, j_d;
  logic                     keyed_flag_q, keyed_flag_d;
  logic                     valid_q, valid_d;
  logic [rc4_pkg::IdxW-1:0] k_q, k_d, kk_q, kk_d, l_q, l_d;
  logic [rc4_pkg::IdxW-1:0] a_q, a_d, b_q, b_d, t_q, t_d;
  logic [7:0]               ks_q, ks_d;
  logic                     keyed_out_q, keyed_out_d;
  logic [rc4_pkg::IdxW-1:0] l_sum, j_sum, i_inc;

  logic                     s_we;
  logic [rc4_pkg::IdxW-1:0] s_waddr, s_wdata, s_raddr, s_rdata;
  logic                     k_we;
  logic [rc4_pkg::IdxW-1:0] k_rdata;

  assign accept = start && (state_q == rc4_pkg::StIdle);
  assign key_cnt_inc = (key_cnt_q < rc4_pkg::KeyCntFull) ? key_cnt_q + 9'd1 : key_cnt_q;
  assign l_sum = l_q + s_rdata + k_rdata;
  assign j_sum = j_q + s_rdata;
  assign i_inc = i_q + 8'd1;

  rc4_ram #(
    .Depth(rc4_pkg::TableDepth),
    .Width(rc4_pkg::IdxW)
  ) u_perm_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  rc4_ram #(
    .Depth(rc4_pkg::TableDepth),
    .Width(rc4_pkg::IdxW)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (k_we),
    .waddr_i(key_cnt_q[rc4_pkg::IdxW-1:0]),
    .wdata_i(key_byte_i),
    .raddr_i(kk_q),
    .rdata_o(k_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      rc4_pkg::StIdle: begin
        if (accept) begin
          if (mode_i == rc4_pkg::ModeKeyLoad) begin
            if (key_last_i) begin
              state_d = rc4_pkg::StInit;
            end
          end else if (keyed_flag_q) begin
            state_d = rc4_pkg::StRqRdI;
          end
        end
      end
      rc4_pkg::StInit: begin
        if (k_q == rc4_pkg::IdxLast) begin
          state_d = rc4_pkg::StKsRdK;
        end
      end
      rc4_pkg::StKsRdK: state_d = rc4_pkg::StKsRdL;
      rc4_pkg::StKsRdL: state_d = rc4_pkg::StKsWrK;
      rc4_pkg::StKsWrK: state_d = rc4_pkg::StKsWrL;
      rc4_pkg::StKsWrL: begin
        state_d = (k_q == rc4_pkg::IdxLast) ? rc4_pkg::StIdle : rc4_pkg::StKsRdK;
      end
      rc4_pkg::StRqRdI: state_d = rc4_pkg::StRqRdJ;
      rc4_pkg::StRqRdJ: state_d = rc4_pkg::StRqWrI;
      rc4_pkg::StRqWrI: state_d = rc4_pkg::StRqWrJ;
      rc4_pkg::StRqWrJ: state_d = rc4_pkg::StIdle;
      default: state_d = rc4_pkg::StIdle;
    endcase
  end

  always_comb begin
    key_cnt_d    = key_cnt_q;
    key_len_d    = key_len_q;
    i_d          = i_q;
    j_d          = j_q;
    keyed_flag_d = keyed_flag_q;
    valid_d      = 1'b0;
    k_d          = k_q;
    kk_d         = kk_q;
    l_d          = l_q;
    a_d          = a_q;
    b_d          = b_q;
    t_d          = t_q;
    ks_d         = ks_q;
    keyed_out_d  = keyed_out_q;
    s_we         = 1'b0;
    s_waddr      = k_q;
    s_wdata      = k_q;
    s_raddr      = k_q;
    k_we         = 1'b0;
    case (state_q)
      rc4_pkg::StIdle: begin
        if (accept) begin
          if (mode_i == rc4_pkg::ModeKeyLoad) begin
            // Bytes beyond the store's depth are dropped; the count saturates.
            k_we      = key_cnt_q < rc4_pkg::KeyCntFull;
            key_cnt_d = key_cnt_inc;
            if (key_last_i) begin
              key_len_d = key_cnt_inc;
              key_cnt_d = '0;
              k_d       = '0;
            end
          end else if (!keyed_flag_q) begin
            valid_d     = 1'b1;
            ks_d        = '0;
            keyed_out_d = 1'b0;
          end
        end
      end
      rc4_pkg::StInit: begin
        s_we    = 1'b1;
        s_waddr = k_q;
        s_wdata = k_q;
        k_d     = k_q + 8'd1;
        l_d     = '0;
        kk_d    = '0;
      end
      rc4_pkg::StKsRdK: begin
        s_raddr = k_q;
      end
      rc4_pkg::StKsRdL: begin
        l_d     = l_sum;
        s_raddr = l_sum;
        a_d     = s_rdata;
      end
      rc4_pkg::StKsWrK: begin
        s_we    = 1'b1;
        s_waddr = k_q;
        s_wdata = s_rdata;
      end
      rc4_pkg::StKsWrL: begin
        s_we    = 1'b1;
        s_waddr = l_q;
        s_wdata = a_q;
        k_d     = k_q + 8'd1;
        kk_d    = (({1'b0, kk_q} + 9'd1) == key_len_q) ? '0 : kk_q + 8'd1;
        if (k_q == rc4_pkg::IdxLast) begin
          i_d          = '0;
          j_d          = '0;
          keyed_flag_d = 1'b1;
        end
      end
      rc4_pkg::StRqRdI: begin
        s_raddr = i_inc;
        i_d     = i_inc;
      end
      rc4_pkg::StRqRdJ: begin
        s_raddr = j_sum;
        j_d     = j_sum;
        a_d     = s_rdata;
      end
      rc4_pkg::StRqWrI: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata;
        b_d     = s_rdata;
        t_d     = a_q + s_rdata;
        s_raddr = a_q + s_rdata;
      end
      rc4_pkg::StRqWrJ: begin
        s_we        = 1'b1;
        s_waddr     = j_q;
        s_wdata     = a_q;
        valid_d     = 1'b1;
        keyed_out_d = 1'b1;
        // The output entry may be one of the two just swapped, whose new
        // values are not yet visible through the read port.
        if (t_q == i_q) begin
          ks_d = b_q;
        end else if (t_q == j_q) begin
          ks_d = a_q;
        end else begin
          ks_d = s_rdata;
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rc4_pkg::StIdle;
      key_cnt_q    <= '0;
      i_q          <= '0;
      j_q          <= '0;
      keyed_flag_q <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      key_cnt_q    <= key_cnt_d;
      i_q          <= i_d;
      j_q          <= j_d;
      keyed_flag_q <= keyed_flag_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_len_q   <= key_len_d;
    k_q         <= k_d;
    kk_q        <= kk_d;
    l_q         <= l_d;
    a_q         <= a_d;
    b_q         <= b_d;
    t_q         <= t_d;
    ks_q        <= ks_d;
    keyed_out_q <= keyed_out_d;
  end

  assign busy             = state_q != rc4_pkg::StIdle;
  assign valid_o          = valid_q;
  assign keystream_byte_o = ks_q;
  assign keyed_o          = keyed_out_q;

  // A result is only shown once the controller has returned to idle.
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  a_unkeyed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !keyed_o) |-> (keystream_byte_o == 8'd0))
    else $error("unkeyed result is not zero");

  a_keyed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keyed_flag_q |=> keyed_flag_q)
    else $error("keyed flag dropped");

  a_key_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_cnt_q <= rc4_pkg::KeyCntFull)
    else $error("key count beyond store depth");

endmodule
